>>> sv/json_string_unescaper_core_defines.svh
// Assertion macros shared by the JSON string unescaper RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef JSON_STRING_UNESCAPER_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPER_CORE_DEFINES_SVH

// Check an implication or expression on every clock edge outside reset.
`define JSU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Check that a condition never holds outside reset.
`define JSU_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error(msg);

`endif

>>> sv/jsu_pkg.sv
// Shared types, codes and constants of the JSON string unescaper.
// No dependencies; used by jsu_front, jsu_queue, jsu_back and the top level.
`default_nettype none

package jsu_pkg;

    // Parser phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_STR  = 3'd1;
    localparam logic [2:0] PH_ESC  = 3'd2;
    localparam logic [2:0] PH_HEX  = 3'd3;

    // Result kinds
    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_OPEN   = 3'd1;
    localparam logic [2:0] ERR_UNTERM    = 3'd2;
    localparam logic [2:0] ERR_UNTERM_ES = 3'd3;
    localparam logic [2:0] ERR_BAD_ESC   = 3'd4;
    localparam logic [2:0] ERR_BAD_UNI   = 3'd5;

    // Characters
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    // UTF-8 encoding
    localparam logic [15:0] UTF8_TWO_MIN   = 16'h0080;
    localparam logic [15:0] UTF8_THREE_MIN = 16'h0800;
    localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
    localparam logic [7:0]  UTF8_CONT      = 8'h80;
    localparam logic [7:0]  UTF8_CONT_MASK = 8'h3F;

    // Default depth of the job queue
    localparam int QUEUE_DEPTH_DEF = 4;

    // One classified input byte: up to three results to emit
    typedef struct packed {
        logic [1:0] count;   // results in this job, 1 to 3
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] kind;
        logic [2:0] err;
    } job_t;

    // Queue fill status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

>>> sv/json_string_unescaper_core.sv
// Top level of the JSON string unescaper: front parser, job queue, back emitter.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
//
//  Channel | Ports                                          | Direction
//  --------+------------------------------------------------+----------
//  input   | s_valid s_ready s_in_byte s_end_of_text        | in
//  result  | m_valid m_ready m_out_byte m_kind m_error_code | out
//          | m_last_of_run                                  |
//
// One input byte is taken per cycle while the job queue has room. A byte that
// ends a \uXXXX escape yields up to three UTF-8 results, and the back part
// emits one result per cycle through its output register while m_ready allows,
// so such a byte holds the result side until all its results are out; the queue absorbs the difference.
// Each job is written into the queue and then loaded into the output register.
// aresetn is synchronous, active low; it empties the queue and idles the parser.
// A stalled result side fills the queue and then drops s_ready.
`default_nettype none

module json_string_unescaper_core #(
    parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input channel
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_end_of_text,
    // result channel
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic [1:0]      m_kind,
    output logic [2:0]      m_error_code,
    output logic            m_last_of_run
);

    jsu_pkg::queue_status_t q_status;
    jsu_pkg::job_t          push_job;
    jsu_pkg::job_t          head;
    logic                   push;
    logic                   pop;

    // Parse and classify each transaction; push a job when it yields results
    jsu_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_text (s_end_of_text),
        .q_status      (q_status),
        .push          (push),
        .push_job      (push_job)
    );

    // Hold jobs so the parser advances while results wait
    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    // Drain each job one result transaction at a time
    jsu_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_kind        (m_kind),
        .m_error_code  (m_error_code),
        .m_last_of_run (m_last_of_run)
    );

endmodule

`default_nettype wire

>>> sv/jsu_front.sv
// Front part: accepts raw bytes, tracks the string phase and classifies
// each byte into a job for the queue. Depends on jsu_pkg and the defines header.
`default_nettype none
`include "json_string_unescaper_core_defines.svh"

module jsu_front (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [7:0]           s_in_byte,
    input  wire logic                 s_end_of_text,
    input  wire jsu_pkg::queue_status_t q_status,
    output logic                      push,
    output jsu_pkg::job_t             push_job
);

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [11:0] code_accum_reg, code_accum_next;

    logic        accept;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] code;
    logic        emit;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign code    = {code_accum_reg, hex_val};

    // Hex digit decode, either case
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (s_in_byte >= 8'h30 && s_in_byte <= 8'h39) begin
            hex_val = 4'(s_in_byte - 8'h30);
        end else if (s_in_byte >= 8'h61 && s_in_byte <= 8'h66) begin
            hex_val = 4'(s_in_byte - 8'h57);
        end else if (s_in_byte >= 8'h41 && s_in_byte <= 8'h46) begin
            hex_val = 4'(s_in_byte - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        phase_next      = phase_reg;
        hex_count_next  = hex_count_reg;
        code_accum_next = code_accum_reg;
        emit            = 1'b0;
        push_job        = '0;
        push_job.count  = 2'd1;
        push_job.kind   = jsu_pkg::KIND_BYTE;
        push_job.err    = jsu_pkg::ERR_NONE;

        case (phase_reg)
            jsu_pkg::PH_STR: begin
                emit = 1'b1;
                if (s_end_of_text) begin
                    push_job.kind = jsu_pkg::KIND_ERR;
                    push_job.err  = jsu_pkg::ERR_UNTERM;
                    phase_next    = jsu_pkg::PH_IDLE;
                end else if (s_in_byte == jsu_pkg::CH_QUOTE) begin
                    push_job.kind = jsu_pkg::KIND_END;
                    phase_next    = jsu_pkg::PH_IDLE;
                end else if (s_in_byte == jsu_pkg::CH_BSLASH) begin
                    emit       = 1'b0;
                    phase_next = jsu_pkg::PH_ESC;
                end else begin
                    push_job.b0 = s_in_byte;
                end
            end
            jsu_pkg::PH_ESC: begin
                emit       = 1'b1;
                phase_next = jsu_pkg::PH_STR;
                if (s_end_of_text) begin
                    push_job.kind = jsu_pkg::KIND_ERR;
                    push_job.err  = jsu_pkg::ERR_UNTERM_ES;
                    phase_next    = jsu_pkg::PH_IDLE;
                end else begin
                    case (s_in_byte)
                        jsu_pkg::CH_QUOTE:  push_job.b0 = jsu_pkg::CH_QUOTE;
                        jsu_pkg::CH_BSLASH: push_job.b0 = jsu_pkg::CH_BSLASH;
                        jsu_pkg::CH_SLASH:  push_job.b0 = jsu_pkg::CH_SLASH;
                        jsu_pkg::CH_B:      push_job.b0 = 8'h08;
                        jsu_pkg::CH_F:      push_job.b0 = 8'h0C;
                        jsu_pkg::CH_N:      push_job.b0 = 8'h0A;
                        jsu_pkg::CH_R:      push_job.b0 = 8'h0D;
                        jsu_pkg::CH_T:      push_job.b0 = 8'h09;
                        jsu_pkg::CH_U: begin
                            emit            = 1'b0;
                            phase_next      = jsu_pkg::PH_HEX;
                            hex_count_next  = 2'd0;
                            code_accum_next = '0;
                        end
                        default: begin
                            push_job.kind = jsu_pkg::KIND_ERR;
                            push_job.err  = jsu_pkg::ERR_BAD_ESC;
                            phase_next    = jsu_pkg::PH_IDLE;
                        end
                    endcase
                end
            end
            jsu_pkg::PH_HEX: begin
                if (s_end_of_text || !hex_ok) begin
                    emit            = 1'b1;
                    push_job.kind   = jsu_pkg::KIND_ERR;
                    push_job.err    = jsu_pkg::ERR_BAD_UNI;
                    phase_next      = jsu_pkg::PH_IDLE;
                    hex_count_next  = 2'd0;
                    code_accum_next = '0;
                end else if (hex_count_reg == 2'd3) begin
                    // Fourth digit: encode the code point as UTF-8
                    emit            = 1'b1;
                    phase_next      = jsu_pkg::PH_STR;
                    hex_count_next  = 2'd0;
                    code_accum_next = '0;
                    if (code < jsu_pkg::UTF8_TWO_MIN) begin
                        push_job.b0 = code[7:0];
                    end else if (code < jsu_pkg::UTF8_THREE_MIN) begin
                        push_job.count = 2'd2;
                        push_job.b0    = jsu_pkg::UTF8_LEAD2 | {3'd0, code[10:6]};
                        push_job.b1    = jsu_pkg::UTF8_CONT
                                       | (jsu_pkg::UTF8_CONT_MASK & {2'd0, code[5:0]});
                    end else begin
                        push_job.count = 2'd3;
                        push_job.b0    = jsu_pkg::UTF8_LEAD3 | {4'd0, code[15:12]};
                        push_job.b1    = jsu_pkg::UTF8_CONT
                                       | (jsu_pkg::UTF8_CONT_MASK & {2'd0, code[11:6]});
                        push_job.b2    = jsu_pkg::UTF8_CONT
                                       | (jsu_pkg::UTF8_CONT_MASK & {2'd0, code[5:0]});
                    end
                end else begin
                    hex_count_next  = hex_count_reg + 2'd1;
                    code_accum_next = code[11:0];
                end
            end
            default: begin
                hex_count_next  = 2'd0;
                code_accum_next = '0;
                if (!s_end_of_text && s_in_byte == jsu_pkg::CH_QUOTE) begin
                    phase_next = jsu_pkg::PH_STR;
                end else begin
                    emit          = 1'b1;
                    push_job.kind = jsu_pkg::KIND_ERR;
                    push_job.err  = jsu_pkg::ERR_NO_OPEN;
                    phase_next    = jsu_pkg::PH_IDLE;
                end
            end
        endcase
    end

    assign push = accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= jsu_pkg::PH_IDLE;
            hex_count_reg  <= 2'd0;
            code_accum_reg <= '0;
        end else if (accept) begin
            phase_reg      <= phase_next;
            hex_count_reg  <= hex_count_next;
            code_accum_reg <= code_accum_next;
        end
    end

    `JSU_ASSERT(a_eot_to_idle, aclk, aresetn, (s_valid && s_ready && s_end_of_text) |=> (phase_reg == jsu_pkg::PH_IDLE), "end of text did not return the parser to idle")

endmodule

`default_nettype wire

>>> sv/jsu_queue.sv
// Job queue between the front and back parts: a small flop FIFO of jobs.
// Depends on jsu_pkg and the defines header.
`default_nettype none
`include "json_string_unescaper_core_defines.svh"

module jsu_queue #(
    parameter int DEPTH = jsu_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire jsu_pkg::job_t          push_job,
    input  wire logic                   pop,
    output jsu_pkg::job_t               head,
    output jsu_pkg::queue_status_t      status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    jsu_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `JSU_ASSERT_NEVER(a_no_overflow, aclk, aresetn, push && status.full, "push into a full job queue")
    `JSU_ASSERT_NEVER(a_no_underflow, aclk, aresetn, pop && status.empty, "pop from an empty job queue")

endmodule

`default_nettype wire

>>> sv/jsu_back.sv
// Back part: walks the head job one result per cycle into the output register while it is empty or being taken.
// Depends on jsu_pkg and the defines header.
`default_nettype none
`include "json_string_unescaper_core_defines.svh"

module jsu_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire jsu_pkg::job_t          head,
    input  wire jsu_pkg::queue_status_t q_status,
    output logic                        pop,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [7:0]                  m_out_byte,
    output logic [1:0]                  m_kind,
    output logic [2:0]                  m_error_code,
    output logic                        m_last_of_run
);

    logic       m_valid_reg;
    logic [7:0] m_out_byte_reg;
    logic [1:0] m_kind_reg;
    logic [2:0] m_error_code_reg;
    logic       m_last_reg;
    logic [1:0] idx_reg, idx_next;

    logic       load;
    logic       last;
    logic [7:0] sel_byte;

    assign load = !q_status.empty && (!m_valid_reg || m_ready);
    assign last = (idx_reg == head.count - 2'd1);
    assign pop  = load && last;

    always_comb begin
        case (idx_reg)
            2'd0:    sel_byte = head.b0;
            2'd1:    sel_byte = head.b1;
            2'd2:    sel_byte = head.b2;
            default: sel_byte = 8'd0;
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_out_byte_reg   <= sel_byte;
            m_kind_reg       <= head.kind;
            m_error_code_reg <= head.err;
            m_last_reg       <= last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_byte    = m_out_byte_reg;
    assign m_kind        = m_kind_reg;
    assign m_error_code  = m_error_code_reg;
    assign m_last_of_run = m_last_reg;

    `JSU_ASSERT(a_single_non_byte, aclk, aresetn, (m_valid_reg && (m_kind_reg != jsu_pkg::KIND_BYTE)) |-> m_last_reg, "end or error result not marked last of run")
    `JSU_ASSERT_NEVER(a_idx_in_job, aclk, aresetn, !q_status.empty && (idx_reg >= head.count), "result index ran past the head job")

endmodule

`default_nettype wire
